// ===== rtl/aesks_pkg.sv =====
package aesks_pkg;

    // Default configuration
    localparam int DEF_ROUNDS    = 10;
    localparam int DEF_MAX_BYTES = 1024;
    localparam int MAX_BLOCKS    = 64;

    // Seed register indexes
    localparam logic [1:0] REG_SEED0 = 2'd0;
    localparam logic [1:0] REG_SEED1 = 2'd1;
    localparam logic [1:0] REG_SEED2 = 2'd2;
    localparam logic [1:0] REG_SEED3 = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLOCK,
        ST_OUT,
        ST_REKEY_LO,
        ST_REKEY_HI,
        ST_EXPAND
    } state_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // State byte m sits at bits [8m+7:8m]
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        int src;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = (((c + r) % 4) * 4) + r;
                t[8*(c*4+r) +: 8] = SBOX[s[8*src +: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = s[8*(4*c)   +: 8];
            a1  = s[8*(4*c+1) +: 8];
            a2  = s[8*(4*c+2) +: 8];
            a3  = s[8*(4*c+3) +: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[8*(4*c)   +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

// ===== rtl/aesks_keyexp.sv =====
module aesks_keyexp #(
    parameter int ROUNDS = aesks_pkg::DEF_ROUNDS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [255:0] key,
    input  logic [3:0]   rd_idx,
    output logic [127:0] rd_data,
    output logic         busy,
    output logic         done
);

    localparam bit WIDE  = (ROUNDS == 14);
    localparam int NR    = WIDE ? 14 : 10;
    localparam int NK    = WIDE ? 8 : 4;
    localparam int TOTAL = 4 * (NR + 1);

    logic         busy_reg;
    logic         done_reg;
    logic [5:0]   i_reg;
    logic [7:0]   rcon_reg;
    logic [31:0]  win_reg [8];
    logic [127:0] rk_reg [15];

    logic [31:0] prev_w;
    logic [31:0] t_w;
    logic [31:0] new_w;
    logic        rot_step;
    logic        sub_step;

    // Next schedule word from the sliding window
    always_comb
    begin
        prev_w   = win_reg[NK-1];
        rot_step = ((i_reg % NK) == 6'd0);
        sub_step = WIDE && ((i_reg % NK) == 6'd4);
        if (rot_step)
        begin
            t_w = aesks_pkg::sub_word({prev_w[7:0], prev_w[31:8]}) ^ {24'd0, rcon_reg};
        end
        else if (sub_step)
        begin
            t_w = aesks_pkg::sub_word(prev_w);
        end
        else
        begin
            t_w = prev_w;
        end
        new_w = win_reg[0] ^ t_w;
    end

    assign rd_data = rk_reg[rd_idx];
    assign busy    = busy_reg;
    assign done    = done_reg;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
            rcon_reg <= 8'h01;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg    <= 6'(NK);
                rcon_reg <= 8'h01;
            end
            else if (busy_reg)
            begin
                i_reg <= i_reg + 6'd1;
                if (rot_step)
                begin
                    rcon_reg <= aesks_pkg::xtime(rcon_reg);
                end
                if (i_reg == 6'(TOTAL - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Window and round key store
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int k = 0; k < 8; k++)
            begin
                win_reg[k] <= key[32*k +: 32];
            end
            rk_reg[0] <= key[127:0];
            if (WIDE)
            begin
                rk_reg[1] <= key[255:128];
            end
        end
        else if (busy_reg)
        begin
            for (int k = 0; k < NK - 1; k++)
            begin
                win_reg[k] <= win_reg[k+1];
            end
            win_reg[NK-1] <= new_w;
            if (i_reg[1:0] == 2'd3)
            begin
                rk_reg[i_reg[5:2]] <= {new_w, win_reg[NK-1], win_reg[NK-2], win_reg[NK-3]};
            end
        end
    end

endmodule

// ===== rtl/aesks_cipher.sv =====
module aesks_cipher #(
    parameter int ROUNDS = aesks_pkg::DEF_ROUNDS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] blk_in,
    output logic [3:0]   rk_idx,
    input  logic [127:0] rk_data,
    output logic         done,
    output logic [127:0] result
);

    localparam int NR = (ROUNDS == 14) ? 14 : 10;

    logic         busy_reg;
    logic         done_reg;
    logic [3:0]   round_reg;
    logic [127:0] state_reg;
    logic [127:0] mid_reg;
    logic [127:0] result_reg;

    logic [127:0] ss;
    logic [127:0] full_round;

    // Shared round unit
    assign ss         = aesks_pkg::sub_shift(state_reg);
    assign full_round = aesks_pkg::mix_columns(ss) ^ rk_data;
    assign rk_idx     = busy_reg ? round_reg : 4'd0;
    assign done       = done_reg;
    assign result     = result_reg;

    // Round counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= 4'd1;
            end
            else if (busy_reg)
            begin
                round_reg <= round_reg + 4'd1;
                if (round_reg == 4'(NR))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Cipher state
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            state_reg <= blk_in ^ rk_data;
        end
        else if (busy_reg)
        begin
            if (round_reg == 4'(NR))
            begin
                result_reg <= ss ^ rk_data ^ mid_reg;
            end
            else
            begin
                state_reg <= full_round;
                if (round_reg == 4'(NR / 2))
                begin
                    mid_reg <= full_round;
                end
            end
        end
    end

endmodule

// ===== rtl/aes_ctr_keystream_rekeying.sv =====
// AES-CTR keystream generator with key erasure. A request on byte_count
// returns ceil(n/16) blocks (n clamped to MAX_BYTES and 64 blocks), each the
// AES encryption of the counter XORed with the middle-round state; the last
// block carries last_block and its valid byte count. Each block runs in the
// single shared round unit, then is held for the output transfer; the next
// block starts only once it is taken. After every request the block rekeys:
// one (AES-128) or two (AES-256) more cipher passes, then key expansion at
// one schedule word per cycle. The same expansion runs after reset and after
// any seed register write, and in_ready stays low until it finishes. in_ready
// is high only when idle.
module aes_ctr_keystream_rekeying #(
    parameter int ROUNDS    = aesks_pkg::DEF_ROUNDS,
    parameter int MAX_BYTES = aesks_pkg::DEF_MAX_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [10:0] byte_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] block_low,
    output logic [63:0] block_high,
    output logic [4:0]  valid_bytes,
    output logic        last_block
);

    localparam bit WIDE      = (ROUNDS == 14);
    localparam int CAP       = 16 * aesks_pkg::MAX_BLOCKS;
    localparam int LIMIT     = (MAX_BYTES < CAP) ? MAX_BYTES : CAP;
    localparam logic [63:0] FLIP = 64'h8000_0000_0000_0000;

    aesks_pkg::state_t state_reg, state_next;

    logic [63:0]  seed_reg [4];
    logic         pending_reg;
    logic [63:0]  ctr_lo_reg;
    logic [63:0]  ctr_hi_reg;
    logic [10:0]  left_reg;
    logic [127:0] key_lo_reg;
    logic         out_valid_reg;
    logic [63:0]  block_low_reg;
    logic [63:0]  block_high_reg;
    logic [4:0]   valid_bytes_reg;
    logic         last_block_reg;

    logic         core_start;
    logic [127:0] core_blk;
    logic [3:0]   rk_idx;
    logic [127:0] rk_data;
    logic         core_done;
    logic [127:0] core_result;
    logic         kx_start;
    logic [255:0] kx_key;
    logic         kx_busy;
    logic         kx_done;

    logic         in_fire;
    logic         out_fire;
    logic [10:0]  req_len;
    logic [4:0]   blk_bytes;
    logic [255:0] seed_key;

    aesks_cipher #(.ROUNDS(ROUNDS)) u_cipher (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (core_start),
        .blk_in (core_blk),
        .rk_idx (rk_idx),
        .rk_data(rk_data),
        .done   (core_done),
        .result (core_result)
    );

    aesks_keyexp #(.ROUNDS(ROUNDS)) u_keyexp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (kx_start),
        .key    (kx_key),
        .rd_idx (rk_idx),
        .rd_data(rk_data),
        .busy   (kx_busy),
        .done   (kx_done)
    );

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign req_len  = (byte_count > 11'(LIMIT)) ? 11'(LIMIT) : byte_count;
    assign blk_bytes = (left_reg > 11'd16) ? 5'd16 : left_reg[4:0];
    assign seed_key = {seed_reg[3], seed_reg[2], seed_reg[1], seed_reg[0]};

    assign out_valid   = out_valid_reg;
    assign block_low   = block_low_reg;
    assign block_high  = block_high_reg;
    assign valid_bytes = valid_bytes_reg;
    assign last_block  = last_block_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            aesks_pkg::ST_IDLE:
            begin
                if (pending_reg && !kx_busy)
                begin
                    state_next = aesks_pkg::ST_EXPAND;
                end
                else if (in_fire)
                begin
                    state_next = (req_len != 11'd0) ? aesks_pkg::ST_BLOCK
                                                    : aesks_pkg::ST_REKEY_LO;
                end
            end
            aesks_pkg::ST_BLOCK:
            begin
                if (core_done)
                begin
                    state_next = aesks_pkg::ST_OUT;
                end
            end
            aesks_pkg::ST_OUT:
            begin
                if (out_fire)
                begin
                    state_next = (left_reg != 11'd0) ? aesks_pkg::ST_BLOCK
                                                     : aesks_pkg::ST_REKEY_LO;
                end
            end
            aesks_pkg::ST_REKEY_LO:
            begin
                if (core_done)
                begin
                    state_next = WIDE ? aesks_pkg::ST_REKEY_HI : aesks_pkg::ST_EXPAND;
                end
            end
            aesks_pkg::ST_REKEY_HI:
            begin
                if (core_done)
                begin
                    state_next = aesks_pkg::ST_EXPAND;
                end
            end
            aesks_pkg::ST_EXPAND:
            begin
                if (kx_done)
                begin
                    state_next = aesks_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aesks_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready   = 1'b0;
        core_start = 1'b0;
        core_blk   = {ctr_hi_reg, ctr_lo_reg};
        kx_start   = 1'b0;
        kx_key     = {128'd0, core_result};
        case (state_reg)
            aesks_pkg::ST_IDLE:
            begin
                if (pending_reg)
                begin
                    kx_start = !kx_busy;
                    kx_key   = seed_key;
                end
                else
                begin
                    in_ready   = 1'b1;
                    core_start = in_valid;
                    if (req_len == 11'd0)
                    begin
                        core_blk = {ctr_hi_reg ^ FLIP, ctr_lo_reg};
                    end
                end
            end
            aesks_pkg::ST_OUT:
            begin
                core_start = out_fire;
                if (left_reg == 11'd0)
                begin
                    core_blk = {ctr_hi_reg ^ FLIP, ctr_lo_reg};
                end
            end
            aesks_pkg::ST_REKEY_LO:
            begin
                if (WIDE)
                begin
                    core_start = core_done;
                    core_blk   = {ctr_hi_reg ^ FLIP, ctr_lo_reg + 64'd1};
                end
                else
                begin
                    kx_start = core_done;
                end
            end
            aesks_pkg::ST_REKEY_HI:
            begin
                kx_start = core_done;
                kx_key   = {core_result, key_lo_reg};
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aesks_pkg::ST_IDLE;
            pending_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                seed_reg[k] <= '0;
            end
            ctr_lo_reg <= '0;
            ctr_hi_reg <= '0;
            left_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Seed writes schedule a reload
            if (cfg_we)
            begin
                seed_reg[cfg_index] <= cfg_data;
                pending_reg         <= 1'b1;
            end
            else if (state_reg == aesks_pkg::ST_IDLE && pending_reg && !kx_busy)
            begin
                pending_reg <= 1'b0;
                ctr_lo_reg  <= WIDE ? 64'd0 : seed_reg[2];
                ctr_hi_reg  <= WIDE ? 64'd0 : seed_reg[3];
            end

            if (in_fire)
            begin
                left_reg <= req_len;
            end

            // Block finished: count it off
            if (state_reg == aesks_pkg::ST_BLOCK && core_done)
            begin
                out_valid_reg <= 1'b1;
                ctr_lo_reg    <= ctr_lo_reg + 64'd1;
                left_reg      <= left_reg - 11'(blk_bytes);
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output and rekey payload
    always_ff @(posedge clk)
    begin
        if (state_reg == aesks_pkg::ST_BLOCK && core_done)
        begin
            block_low_reg   <= core_result[63:0];
            block_high_reg  <= core_result[127:64];
            valid_bytes_reg <= blk_bytes;
            last_block_reg  <= (left_reg <= 11'd16);
        end
        if (state_reg == aesks_pkg::ST_REKEY_LO && core_done)
        begin
            key_lo_reg <= core_result;
        end
    end

endmodule

// ===== rtl/aesks_checker.sv =====
module aesks_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [4:0] valid_bytes,
    input logic       last_block
);

    // Held result stays until transferred
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    // No new request while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while result pending");

    // Accepted request blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after transfer");

    // Valid byte count is 1 to 16; only the final block may be short
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (valid_bytes != 5'd0) && (valid_bytes <= 5'd16)
                      && (last_block || valid_bytes == 5'd16))
        else $error("bad valid byte count");

endmodule

bind aes_ctr_keystream_rekeying aesks_checker u_aesks_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .valid_bytes(valid_bytes),
    .last_block (last_block)
);
